[rtl/tkbd_pkg.sv]
// shared types and constants for the touch key baseline detector
// no dependencies; imported by every module of the block
package tkbd_pkg;

   localparam int CHANNEL_BITS   = 3;
   localparam int MASK_BITS      = 8;
   localparam int THRESHOLD_BITS = 12;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 12'd500;

   typedef logic [MASK_BITS-1:0] mask_type;

   // control for the processing stage, shared by the channel and report units
   typedef struct packed {
      logic fire;
      logic end_of_scan;
   } step_type;

endpackage

[rtl/tkbd_ifs.sv]
// channel interfaces of the touch key baseline detector: samples, results, threshold
// depends on tkbd_pkg for the fixed field widths
interface tkbd_req_if #(
   parameter int SAMPLE_BITS = 12
);
   import tkbd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] channel;
   logic [SAMPLE_BITS-1:0]  sample;
   logic                    end_of_scan;

   modport source (output valid, channel, sample, end_of_scan, input ready);
   modport sink   (input valid, channel, sample, end_of_scan, output ready);
endinterface

interface tkbd_rsp_if;
   import tkbd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [MASK_BITS-1:0] touch_mask;
   logic                 any_touch;

   modport source (output valid, touch_mask, any_touch, input ready);
   modport sink   (input valid, touch_mask, any_touch, output ready);
endinterface

interface tkbd_csr_if;
   import tkbd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [THRESHOLD_BITS-1:0] touch_threshold;

   modport source (output valid, touch_threshold, input ready);
   modport sink   (input valid, touch_threshold, output ready);
endinterface

[rtl/touch_key_baseline_detector.sv]
// top level of the touch key baseline detector: input register, threshold register
// depends on tkbd_pkg, tkbd_ifs, tkbd_channel_unit and tkbd_report
//
//   port | direction | carries                              | transfer when
//   -----+-----------+--------------------------------------+------------------------
//   req  | in        | channel, sample, end_of_scan         | req.valid && req.ready
//   rsp  | out       | touch_mask, any_touch                | rsp.valid && rsp.ready
//   csr  | in        | touch_threshold                      | csr.valid (always ready)
//
// one sample per cycle while no result is held on rsp; the input register feeds the result register.
// the input register feeds one pass of select, add and compare into the result register.
// reset clears baselines, counts and masks and sets the threshold to 500.
// a result held on rsp stalls the processing stage; req then fills an empty input register only.
module touch_key_baseline_detector #(
   parameter int CHANNEL_COUNT = 8,
   parameter int SAMPLE_BITS   = 12,
   parameter int AVERAGE_SHIFT = 3
) (
   input  logic       clock,
   input  logic       reset,
   tkbd_req_if.sink   req,
   tkbd_rsp_if.source rsp,
   tkbd_csr_if.sink   csr
);
   import tkbd_pkg::*;

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [CHANNEL_BITS-1:0]   in_channel_ff;
   logic [SAMPLE_BITS-1:0]    in_sample_ff;
   logic                      in_eos_ff;
   logic [THRESHOLD_BITS-1:0] threshold_ff;
   logic [THRESHOLD_BITS-1:0] threshold_in;
   logic                      slot_free;
   logic                      req_take;
   step_type                  step;
   mask_type                  mask_next;

   // handshake of the input register and processing stage
   always_comb begin
      step.fire        = in_valid_ff && slot_free;
      step.end_of_scan = in_eos_ff;
      req.ready        = !in_valid_ff || step.fire;
      req_take         = req.valid && req.ready;
      in_valid_in      = req_take || (in_valid_ff && !step.fire);
      threshold_in     = csr.valid ? csr.touch_threshold : threshold_ff;
   end

   assign csr.ready = 1'b1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         threshold_ff <= threshold_in;
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_channel_ff <= req.channel;
         in_sample_ff  <= req.sample;
         in_eos_ff     <= req.end_of_scan;
      end
   end

   tkbd_channel_unit #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .AVERAGE_SHIFT (AVERAGE_SHIFT)
   ) u_channel_unit (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .channel   (in_channel_ff),
      .sample    (in_sample_ff),
      .threshold (threshold_ff),
      .mask_next (mask_next)
   );

   tkbd_report u_report (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .mask_next (mask_next),
      .rsp       (rsp),
      .slot_free (slot_free)
   );

endmodule

[rtl/tkbd_channel_unit.sv]
// per-channel calibration store, baseline compare and live touch mask
// depends on tkbd_pkg
module tkbd_channel_unit #(
   parameter int CHANNEL_COUNT = 8,
   parameter int SAMPLE_BITS   = 12,
   parameter int AVERAGE_SHIFT = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tkbd_pkg::step_type                    step,
   input  logic [tkbd_pkg::CHANNEL_BITS-1:0]     channel,
   input  logic [SAMPLE_BITS-1:0]                sample,
   input  logic [tkbd_pkg::THRESHOLD_BITS-1:0]   threshold,
   output tkbd_pkg::mask_type                    mask_next
);
   import tkbd_pkg::*;

   localparam int SUM_BITS   = SAMPLE_BITS + AVERAGE_SHIFT;
   localparam int COUNT_BITS = AVERAGE_SHIFT + 1;
   localparam int LIMIT_BITS =
      ((SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS) + 1;

   logic [SUM_BITS-1:0]      sum_ff   [CHANNEL_COUNT];
   logic [SUM_BITS-1:0]      sum_in   [CHANNEL_COUNT];
   logic [COUNT_BITS-1:0]    count_ff [CHANNEL_COUNT];
   logic [COUNT_BITS-1:0]    count_in [CHANNEL_COUNT];
   mask_type                 mask_ff;

   logic [CHANNEL_COUNT-1:0] hit;
   logic [SUM_BITS-1:0]      sel_sum;
   logic [COUNT_BITS-1:0]    sel_count;
   logic                     calibrating;
   logic [SAMPLE_BITS-1:0]   baseline;
   logic [LIMIT_BITS-1:0]    limit;
   logic                     over;
   logic [SUM_BITS-1:0]      sum_add;

   // pick the addressed channel; numbers beyond the channel count match nothing
   always_comb begin
      sel_sum   = '0;
      sel_count = '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         hit[i] = (channel == CHANNEL_BITS'(i));
         if (hit[i]) begin
            sel_sum   = sel_sum | sum_ff[i];
            sel_count = sel_count | count_ff[i];
         end
      end
   end

   // calibration add and threshold compare, one bit wider so nothing wraps
   always_comb begin
      calibrating = !sel_count[AVERAGE_SHIFT];
      baseline    = SAMPLE_BITS'(sel_sum >> AVERAGE_SHIFT);
      limit       = LIMIT_BITS'(baseline) + LIMIT_BITS'(threshold);
      over        = LIMIT_BITS'(sample) > limit;
      sum_add     = sel_sum + SUM_BITS'(sample);
   end

   // next state of the store and the mask
   always_comb begin
      mask_next = mask_ff;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         sum_in[i]   = sum_ff[i];
         count_in[i] = count_ff[i];
         if (step.fire && hit[i]) begin
            if (calibrating) begin
               sum_in[i]   = sum_add;
               count_in[i] = count_ff[i] + COUNT_BITS'(1);
            end else begin
               mask_next[i] = over;
            end
         end
      end
   end

   // state registers, all cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            sum_ff[i]   <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         mask_ff <= mask_next;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            sum_ff[i]   <= sum_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

endmodule

[rtl/tkbd_report.sv]
// end-of-scan change detection, reported mask and result register
// depends on tkbd_pkg and tkbd_rsp_if
module tkbd_report (
   input  logic               clock,
   input  logic               reset,
   input  tkbd_pkg::step_type step,
   input  tkbd_pkg::mask_type mask_next,
   tkbd_rsp_if.source         rsp,
   output logic               slot_free
);
   import tkbd_pkg::*;

   mask_type reported_ff;
   mask_type reported_in;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   mask_type rsp_mask_ff;
   logic     rsp_any_ff;
   logic     load;

   // a result leaves on a mask change at the end of a scan round
   always_comb begin
      slot_free    = !rsp_valid_ff || rsp.ready;
      load         = step.fire && step.end_of_scan && (mask_next != reported_ff);
      reported_in  = load ? mask_next : reported_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reported_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_mask_ff <= mask_next;
         rsp_any_ff  <= |mask_next;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.touch_mask = rsp_mask_ff;
   assign rsp.any_touch  = rsp_any_ff;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for touch_key_baseline_detector: sample driver, result monitor, predictor
// depends on tkbd_pkg, the tkbd interfaces and the detector rtl
module tb;
   import tkbd_pkg::*;

   localparam int CHANNEL_COUNT  = 8;
   localparam int SAMPLE_BITS    = 12;
   localparam int AVERAGE_SHIFT  = 3;
   localparam int CAL_SAMPLES    = 1 << AVERAGE_SHIFT;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
   localparam int PHASE_ITEMS    = 148;
   localparam int SETTLE_CYCLES  = 6;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] channel;
      logic [SAMPLE_BITS-1:0]  sample;
      logic                    end_of_scan;
   } touch_sample_type;

   typedef struct packed {
      mask_type touch_mask;
      logic     any_touch;
   } touch_report_type;

   logic clock = 1'b0;
   logic reset;

   tkbd_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   tkbd_rsp_if rsp_ch ();
   tkbd_csr_if csr_ch ();

   touch_key_baseline_detector #(
      .CHANNEL_COUNT(CHANNEL_COUNT),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .AVERAGE_SHIFT(AVERAGE_SHIFT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   always #2 clock = ~clock;

   // predicted detector state
   logic [SAMPLE_BITS+AVERAGE_SHIFT-1:0] baseline_acc [CHANNEL_COUNT];
   logic [3:0]                           warmup_count [CHANNEL_COUNT];
   mask_type                             live_mask;
   mask_type                             shown_mask;
   logic [THRESHOLD_BITS-1:0]            threshold_now;

   touch_sample_type pending_samples[$];
   touch_report_type expected_reports[$];

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  fail_count     = 0;
   int  quiet_cycles   = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   logic idle_enable   = 1'b1;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("mismatch: %s", msg);
   endfunction

   // one accepted sample: calibrate or compare, then report a changed mask at end of scan
   function automatic void track_touch(input logic [CHANNEL_BITS-1:0] ch,
                                       input logic [SAMPLE_BITS-1:0] smp,
                                       input logic eos);
      logic [SAMPLE_BITS:0] limit;
      if (warmup_count[ch] < CAL_SAMPLES) begin
         baseline_acc[ch] = baseline_acc[ch] + smp;
         warmup_count[ch] = warmup_count[ch] + 4'd1;
      end else begin
         // one bit wider than a sample so the sum cannot wrap
         limit = (SAMPLE_BITS+1)'(baseline_acc[ch] >> AVERAGE_SHIFT)
               + (SAMPLE_BITS+1)'(threshold_now);
         live_mask[ch] = ((SAMPLE_BITS+1)'(smp) > limit);
      end
      if (eos && live_mask != shown_mask) begin
         shown_mask = live_mask;
         expected_reports.push_back('{touch_mask: live_mask, any_touch: |live_mask});
      end
   endfunction

   // sample value aimed near the touch limit of a calibrated channel
   function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int ch);
      int lim;
      int v;
      int r;
      if (warmup_count[ch] < CAL_SAMPLES) begin
         if ($urandom_range(0, 3) == 0)
            return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
         return SAMPLE_BITS'($urandom_range(800, 2500));
      end
      lim = int'(baseline_acc[ch] >> AVERAGE_SHIFT) + int'(threshold_now);
      r = $urandom_range(0, 7);
      if (r < 4)
         v = lim + int'($urandom_range(0, 6)) - 3;
      else if (r < 6)
         v = $urandom_range(0, SAMPLE_MAX);
      else if (r == 6)
         v = 0;
      else
         v = SAMPLE_MAX;
      if (v < 0)
         v = 0;
      if (v > SAMPLE_MAX)
         v = SAMPLE_MAX;
      return SAMPLE_BITS'(v);
   endfunction

   task automatic push_sample(input int ch, input int smp, input bit eos);
      pending_samples.push_back('{channel: CHANNEL_BITS'(ch), sample: SAMPLE_BITS'(smp),
                                  end_of_scan: eos});
      queued_count++;
   endtask

   // mostly full scan rounds, some broken rounds of random channels
   task automatic push_scan();
      int n;
      if ($urandom_range(0, 9) < 8) begin
         for (int ch = 0; ch < CHANNEL_COUNT; ch++)
            push_sample(ch, pick_sample(ch), ch == CHANNEL_COUNT - 1);
      end else begin
         n = $urandom_range(1, 10);
         for (int k = 0; k < n; k++)
            push_sample($urandom_range(0, CHANNEL_COUNT - 1), $urandom_range(0, SAMPLE_MAX),
                        $urandom_range(0, 3) == 0);
      end
   endtask

   // wait until every sample has gone in and every report has come out
   task automatic wait_drained();
      do
         @(posedge clock);
      while (accepted_count != queued_count || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESHOLD_BITS-1:0] value);
      @(posedge clock);
      csr_ch.valid           <= 1'b1;
      csr_ch.touch_threshold <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid  <= 1'b0;
      threshold_now = value;
   endtask

   // sample driver, fed from the pending queue
   always @(posedge clock) begin : sample_driver
      touch_sample_type next_item;
      logic             holding;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         holding = req_ch.valid && !req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            accepted_count++;
            track_touch(req_ch.channel, req_ch.sample, req_ch.end_of_scan);
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(0, 2);
               req_ch.valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               next_item = pending_samples.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.channel     <= next_item.channel;
               req_ch.sample      <= next_item.sample;
               req_ch.end_of_scan <= next_item.end_of_scan;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin : report_monitor
      touch_report_type got;
      touch_report_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{touch_mask: rsp_ch.touch_mask, any_touch: rsp_ch.any_touch};
            if (expected_reports.size() == 0) begin
               note_failure($sformatf("unexpected result touch_mask %h any_touch %b",
                                      got.touch_mask, got.any_touch));
            end else begin
               want = expected_reports.pop_front();
               if (got.touch_mask !== want.touch_mask)
                  note_failure($sformatf("touch_mask expected %h actual %h",
                                         want.touch_mask, got.touch_mask));
               if (got.any_touch !== want.any_touch)
                  note_failure($sformatf("any_touch expected %b actual %b",
                                         want.any_touch, got.any_touch));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int target;
      // known values everywhere before the first edge
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.channel         = '0;
      req_ch.sample          = '0;
      req_ch.end_of_scan     = 1'b0;
      rsp_ch.ready           = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.touch_threshold = '0;
      for (int k = 0; k < CHANNEL_COUNT; k++) begin
         baseline_acc[k] = '0;
         warmup_count[k] = '0;
      end
      live_mask     = '0;
      shown_mask    = '0;
      threshold_now = THRESHOLD_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // calibration with the largest samples, end of scan while still calibrating
      push_sample(0, SAMPLE_MAX, 1'b1);
      for (int k = 1; k < CAL_SAMPLES; k++)
         push_sample(0, SAMPLE_MAX, 1'b0);
      for (int k = 0; k < CAL_SAMPLES; k++)
         push_sample(1, 0, k == CAL_SAMPLES - 1);
      // full-scale baseline plus threshold must not wrap
      push_sample(0, SAMPLE_MAX, 1'b1);
      // just above the limit, then on it: touch then mask back to zero
      push_sample(1, int'(THRESHOLD_RESET) + 1, 1'b0);
      push_sample(2, SAMPLE_MAX, 1'b1);
      push_sample(1, int'(THRESHOLD_RESET), 1'b1);
      push_sample(1, SAMPLE_MAX, 1'b1);
      wait_drained();

      // random phases, threshold changed only while drained
      for (int phase = 1; phase <= 7; phase++) begin
         case (phase)
            2: write_threshold('0);
            3: begin
               write_threshold('1);
               idle_enable = 1'b0;
            end
            4: begin
               write_threshold(THRESHOLD_BITS'($urandom_range(0, 300)));
               idle_enable = 1'b1;
            end
            5: write_threshold(THRESHOLD_BITS'($urandom_range(0, 4095)));
            6: write_threshold(THRESHOLD_BITS'(1));
            7: begin
               write_threshold(THRESHOLD_BITS'($urandom_range(50, 200)));
               idle_enable = 1'b0;
            end
            default: ;
         endcase
         target = queued_count + PHASE_ITEMS;
         if (phase == 1) begin
            for (int r = 0; r < CAL_SAMPLES; r++)
               for (int ch = 0; ch < CHANNEL_COUNT; ch++)
                  push_sample(ch, pick_sample(ch), ch == CHANNEL_COUNT - 1);
         end
         while (queued_count < target)
            push_scan();
         wait_drained();
      end

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
